// ----- design/nta_pkg.sv -----
`timescale 1ns / 1ps
// Package for the neighbor table with hold-timer aging.
// Table size, field widths, command codes and sequencer states. No dependencies.
package nta_pkg;

   localparam int MAX_NEIGHBORS = 16;
   localparam int IDX_W         = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int ID_W          = 8;
   localparam int TIMER_W       = 4;
   localparam int COUNT_W       = 5;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NEIGHBORS - 1);

   localparam logic CMD_REFRESH = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   localparam logic [TIMER_W-1:0] HOLD_TIME_RESET = TIMER_W'(4);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } seq_state_type;

endpackage

// ----- design/nta_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the neighbor table: request, response, csr.
// Depends on nta_pkg for field widths.
interface nta_req_if;
   import nta_pkg::*;
   logic            valid;
   logic            ready;
   logic            command;
   logic [ID_W-1:0] neighbor_id;
   modport source (output valid, command, neighbor_id, input ready);
   modport sink   (input valid, command, neighbor_id, output ready);
endinterface

interface nta_rsp_if;
   import nta_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] neighbor_count;
   logic               hit;
   logic               dropped;
   logic [COUNT_W-1:0] expired_count;
   modport source (output valid, neighbor_count, hit, dropped, expired_count, input ready);
   modport sink   (input valid, neighbor_count, hit, dropped, expired_count, output ready);
endinterface

interface nta_csr_if;
   import nta_pkg::*;
   logic               valid;
   logic               ready;
   logic [TIMER_W-1:0] hold_time;
   modport source (output valid, hold_time, input ready);
   modport sink   (input valid, hold_time, output ready);
endinterface

// ----- design/neighbor_table_aging_top.sv -----
`timescale 1ns / 1ps
// Neighbor table with hold-timer aging: table storage, scan sequencer, result register.
// Depends on nta_pkg and the channel interfaces in nta_ifs.sv.
//
//  channel  | dir | payload                                          | word accepted when
//  ---------+-----+--------------------------------------------------+--------------------
//  req_ch   | in  | command, neighbor_id                             | valid & ready
//  rsp_ch   | out | neighbor_count, hit, dropped, expired_count      | valid & ready
//  csr_ch   | in  | hold_time                                        | valid & ready (always ready)
//
// From accept to result, a single compare/decrement unit walks the table one entry per
//   cycle, then the finish state does the add and loads the result register.
// req_ch.ready is high only while the sequencer is idle, so the next word is taken at the
//   earliest in the idle cycle after the finish; no word is taken during a scan or finish.
// The result register holds a finished word while the next request is accepted; a
//   finish stalls only if the previous result has not been taken yet.
// Reset (synchronous, active high) clears all valid bits, the count and hold_time=4.
module neighbor_table_aging_top (
   input  logic     clock,
   input  logic     reset,
   nta_req_if.sink  req_ch,
   nta_rsp_if.source rsp_ch,
   nta_csr_if.sink  csr_ch
);
   import nta_pkg::*;

   // sequencer
   seq_state_type state_ff, state_in;
   logic          req_ready;
   logic          scan_en;
   logic          finish_en;

   // table: valid bits in flops, id and timer rows without reset
   logic [MAX_NEIGHBORS-1:0] entry_valid_ff;
   logic [ID_W-1:0]          entry_node_ff  [MAX_NEIGHBORS];
   logic [TIMER_W-1:0]       entry_timer_ff [MAX_NEIGHBORS];

   // per-item working registers
   logic               cmd_ff;
   logic [ID_W-1:0]    id_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               hit_ff;
   logic               free_found_ff;
   logic [IDX_W-1:0]   free_slot_ff;
   logic [COUNT_W-1:0] expired_ff;
   logic [COUNT_W-1:0] count_ff;      // valid entries, modulo 32
   logic [TIMER_W-1:0] hold_ff;

   // result register
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_hit_ff;
   logic               rsp_dropped_ff;
   logic [COUNT_W-1:0] rsp_expired_ff;

   // shared unit: one entry looked at per cycle
   logic               cur_valid;
   logic [ID_W-1:0]    cur_node;
   logic [TIMER_W-1:0] cur_timer;
   logic               id_match;
   logic               timer_dies;
   logic               do_add;
   logic               do_drop;

   assign cur_valid  = entry_valid_ff[idx_ff];
   assign cur_node   = entry_node_ff[idx_ff];
   assign cur_timer  = entry_timer_ff[idx_ff];
   assign id_match   = cur_valid && (cur_node == id_ff);
   assign timer_dies = (cur_timer <= TIMER_W'(1));

   // add or drop is decided only after the whole table was searched
   assign do_add  = (cmd_ff == CMD_REFRESH) && !hit_ff && free_found_ff;
   assign do_drop = (cmd_ff == CMD_REFRESH) && !hit_ff && !free_found_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (idx_ff == LAST_IDX) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      scan_en   = 1'b0;
      finish_en = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   scan_en   = 1'b1;
         ST_FINISH: finish_en = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_valid_ff <= '0;
         count_ff       <= '0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         hold_ff        <= HOLD_TIME_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_ch.valid) hold_ff <= csr_ch.hold_time;

         if (req_ready && req_ch.valid) idx_ff <= '0;

         if (scan_en) begin
            idx_ff <= idx_ff + IDX_W'(1);
            if ((cmd_ff == CMD_TICK) && cur_valid && timer_dies) begin
               entry_valid_ff[idx_ff] <= 1'b0;
               count_ff               <= count_ff - COUNT_W'(1);
            end
         end

         if (finish_en && do_add) begin
            entry_valid_ff[free_slot_ff] <= 1'b1;
            count_ff                     <= count_ff + COUNT_W'(1);
         end

         if (finish_en)         rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload: table rows, working registers, result fields
   always_ff @(posedge clock) begin
      if (req_ready && req_ch.valid) begin
         cmd_ff        <= req_ch.command;
         id_ff         <= req_ch.neighbor_id;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         free_slot_ff  <= '0;
         expired_ff    <= '0;
      end

      if (scan_en) begin
         if (cmd_ff == CMD_REFRESH) begin
            if (id_match) begin
               entry_timer_ff[idx_ff] <= hold_ff;
               hit_ff                 <= 1'b1;
            end else if (!cur_valid && !free_found_ff) begin
               free_slot_ff  <= idx_ff;
               free_found_ff <= 1'b1;
            end
         end else if (cur_valid) begin
            if (timer_dies) begin
               entry_timer_ff[idx_ff] <= '0;
               expired_ff             <= expired_ff + COUNT_W'(1);
            end else begin
               entry_timer_ff[idx_ff] <= cur_timer - TIMER_W'(1);
            end
         end
      end

      if (finish_en) begin
         if (do_add) begin
            entry_node_ff[free_slot_ff]  <= id_ff;
            entry_timer_ff[free_slot_ff] <= hold_ff;
         end
         rsp_count_ff   <= do_add ? (count_ff + COUNT_W'(1)) : count_ff;
         rsp_hit_ff     <= hit_ff;
         rsp_dropped_ff <= do_drop;
         rsp_expired_ff <= expired_ff;
      end
   end

   assign req_ch.ready          = req_ready;
   assign csr_ch.ready          = 1'b1;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.neighbor_count = rsp_count_ff;
   assign rsp_ch.hit            = rsp_hit_ff;
   assign rsp_ch.dropped        = rsp_dropped_ff;
   assign rsp_ch.expired_count  = rsp_expired_ff;

endmodule

// ----- design/nta_check.sv -----
`timescale 1ns / 1ps
// Port-level checks for the neighbor table, bound to neighbor_table_aging_top.
// Depends on nta_pkg and the top level's channel interfaces.
module nta_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [nta_pkg::COUNT_W-1:0] rsp_count,
   input logic                        rsp_hit,
   input logic                        rsp_dropped,
   input logic [nta_pkg::COUNT_W-1:0] rsp_expired
);
   import nta_pkg::*;

   // a pending result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // ready drops once a word is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted during scan");

   a_hit_xor_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_dropped))
      else $error("hit and dropped both set");

   // expirations only come from ticks, which never hit or drop
   a_tick_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_expired != '0) |-> !rsp_hit && !rsp_dropped)
      else $error("tick result carries refresh flags");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (MAX_NEIGHBORS < 32) |-> rsp_count <= COUNT_W'(MAX_NEIGHBORS))
      else $error("neighbor count above table size");

endmodule

bind neighbor_table_aging_top nta_check u_nta_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_count   (rsp_ch.neighbor_count),
   .rsp_hit     (rsp_ch.hit),
   .rsp_dropped (rsp_ch.dropped),
   .rsp_expired (rsp_ch.expired_count)
);

// ----- tb/tb_neighbor_table_aging_top.sv -----
`timescale 1ns / 1ps
// Testbench for neighbor_table_aging_top: directed and random refresh/tick words, every reply
// checked against a behavioral copy of the table. Depends on nta_pkg and nta_ifs.sv.
module tb_neighbor_table_aging_top;
   import nta_pkg::*;

   // one reply word as the block should produce it
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               hit;
      logic               dropped;
      logic [COUNT_W-1:0] expired;
   } nbr_reply_type;

   logic clock;
   logic reset;

   nta_req_if req_ch ();
   nta_rsp_if rsp_ch ();
   nta_csr_if csr_ch ();

   neighbor_table_aging_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // behavioral table, updated when a word is accepted
   logic               model_valid [MAX_NEIGHBORS];
   logic [ID_W-1:0]    model_node  [MAX_NEIGHBORS];
   logic [TIMER_W-1:0] model_timer [MAX_NEIGHBORS];
   logic [TIMER_W-1:0] model_hold;

   nbr_reply_type expected_replies [$];

   bit quiet;     // both sides run without idle cycles while set
   int errors;
   int n_words, n_hits, n_drops, n_ticks, n_expired;

   always #5 clock = ~clock;

   // Apply one word to the table copy and return the reply it must produce.
   function automatic nbr_reply_type apply_neighbor_word(input logic cmd,
                                                         input logic [ID_W-1:0] id);
      nbr_reply_type r;
      int free_slot;
      int n;
      r = '0;
      free_slot = -1;
      n = 0;
      if (cmd == CMD_REFRESH) begin
         for (int i = 0; i < MAX_NEIGHBORS; i++) begin
            if (model_valid[i]) begin
               if (model_node[i] == id) begin
                  model_timer[i] = model_hold;
                  r.hit = 1'b1;
               end
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         // a miss takes the lowest free slot, or is dropped when the table is full
         if (!r.hit) begin
            if (free_slot >= 0) begin
               model_valid[free_slot] = 1'b1;
               model_node[free_slot]  = id;
               model_timer[free_slot] = model_hold;
            end else begin
               r.dropped = 1'b1;
            end
         end
      end else begin
         // timers at one or zero (zero hold time) are removed on this tick
         for (int i = 0; i < MAX_NEIGHBORS; i++) begin
            if (model_valid[i]) begin
               if (model_timer[i] <= TIMER_W'(1)) begin
                  model_valid[i] = 1'b0;
                  model_timer[i] = '0;
                  r.expired = r.expired + COUNT_W'(1);
               end else begin
                  model_timer[i] = model_timer[i] - TIMER_W'(1);
               end
            end
         end
      end
      for (int i = 0; i < MAX_NEIGHBORS; i++)
         if (model_valid[i])
            n++;
      r.count = COUNT_W'(n);
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // Reply side: random back-pressure, each taken word checked against the oldest
   // expectation.
   always @(posedge clock) begin : reply_monitor
      nbr_reply_type want;
      rsp_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 32);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_replies.size() == 0) begin
            $display("%0t: reply word with none expected, count %0d", $time,
                     rsp_ch.neighbor_count);
            errors++;
         end else begin
            want = expected_replies.pop_front();
            compare_field("neighbor_count", 8'(want.count), 8'(rsp_ch.neighbor_count));
            compare_field("hit", 8'(want.hit), 8'(rsp_ch.hit));
            compare_field("dropped", 8'(want.dropped), 8'(rsp_ch.dropped));
            compare_field("expired_count", 8'(want.expired), 8'(rsp_ch.expired_count));
         end
      end
   end

   // Offer one word, possibly after random idle cycles, and hold it until taken.
   // valid stays high afterwards so back-to-back words need no extra edge.
   task automatic send_word(input logic cmd, input logic [ID_W-1:0] id);
      nbr_reply_type r;
      int gap;
      if (!quiet) begin
         gap = 0;
         while ($urandom_range(99) < 32)
            gap++;
         // now and then a longer pause, so the next word lands at another scan phase
         if ($urandom_range(99) < 5)
            gap += $urandom_range(2, 20);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.valid       <= 1'b1;
      req_ch.command     <= cmd;
      req_ch.neighbor_id <= id;
      do @(posedge clock); while (!req_ch.ready);
      r = apply_neighbor_word(cmd, id);
      expected_replies.insert(expected_replies.size(), r);
      n_words++;
      if (cmd == CMD_TICK)
         n_ticks++;
      if (r.hit)
         n_hits++;
      if (r.dropped)
         n_drops++;
      n_expired += r.expired;
   endtask

   // Sender pauses until every expected reply has been taken.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_replies.size() != 0);
   endtask

   // Register write, only with the block drained.
   task automatic set_hold_time(input logic [TIMER_W-1:0] value);
      wait_for_results();
      csr_ch.valid     <= 1'b1;
      csr_ch.hold_time <= value;
      do @(posedge clock); while (!csr_ch.ready);
      model_hold = value;
      csr_ch.valid <= 1'b0;
   endtask

   // Reset hold time of 4: two adds at the id extremes, a hit, then four ticks
   // age both out together.
   task automatic test_basic_aging();
      send_word(CMD_REFRESH, 8'h00);
      send_word(CMD_REFRESH, 8'hFF);
      send_word(CMD_REFRESH, 8'h00);
      repeat (4) send_word(CMD_TICK, 8'h00);
   endtask

   // Zero hold time: stored with timer zero, gone on the next tick.
   task automatic test_zero_hold();
      set_hold_time(4'd0);
      send_word(CMD_REFRESH, 8'hA5);
      send_word(CMD_REFRESH, 8'hA5);
      send_word(CMD_TICK, 8'h5A);
   endtask

   // Fill all slots, one refused add, a hit on a full table, then one tick at
   // hold time 1 clears everything.
   task automatic test_table_full();
      set_hold_time(4'd1);
      for (int i = 0; i < MAX_NEIGHBORS; i++)
         send_word(CMD_REFRESH, ID_W'(i * 17));
      send_word(CMD_REFRESH, 8'h5A);
      send_word(CMD_REFRESH, ID_W'(3 * 17));
      send_word(CMD_TICK, 8'hFF);
   endtask

   // Phases at several hold times. Ids mostly come from a small pool so the table
   // fills, hits and overflows; some are drawn from the whole range.
   task automatic test_random_traffic();
      logic [TIMER_W-1:0] holds [8];
      logic [ID_W-1:0] id;
      int pool_base, pool_size, tick_pct;
      int words_per_phase;
      holds = '{4'd15, 4'd7, 4'd0, 4'd1, 4'd15, 4'd2, 4'd9, 4'd4};
      holds[5] = $urandom_range(0, 15);
      holds[6] = $urandom_range(0, 15);
      words_per_phase = 210;
      for (int p = 0; p < 8; p++) begin
         set_hold_time(holds[p]);
         quiet     = (p == 4);
         pool_base = $urandom_range(0, 255);
         pool_size = $urandom_range(4, 24);
         tick_pct  = $urandom_range(10, 35);
         for (int k = 0; k < words_per_phase; k++) begin
            if (k == words_per_phase / 2)
               wait_for_results();
            if ($urandom_range(99) < tick_pct) begin
               send_word(CMD_TICK, ID_W'($urandom_range(0, 255)));
            end else begin
               if ($urandom_range(99) < 10)
                  id = ID_W'($urandom_range(0, 255));
               else
                  id = ID_W'(pool_base + $urandom_range(0, pool_size - 1));
               send_word(CMD_REFRESH, id);
            end
         end
         quiet = 1'b0;
      end
   endtask

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      quiet              = 1'b0;
      errors             = 0;
      n_words            = 0;
      n_hits             = 0;
      n_drops            = 0;
      n_ticks            = 0;
      n_expired          = 0;
      req_ch.valid       = 1'b0;
      req_ch.command     = CMD_REFRESH;
      req_ch.neighbor_id = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.hold_time   = '0;
      model_hold         = HOLD_TIME_RESET;
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
         model_valid[i] = 1'b0;
         model_node[i]  = '0;
         model_timer[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_basic_aging();
      test_zero_hold();
      test_table_full();
      test_random_traffic();

      // drain, then allow a full scan for any stray reply
      wait_for_results();
      repeat (2 * MAX_NEIGHBORS + 4) @(posedge clock);

      $display("Ran %0d words: %0d ticks removing %0d entries, %0d refresh hits,",
               n_words, n_ticks, n_expired, n_hits);
      $display("%0d adds refused on a full table, hold times 0 through 15 incl. extremes",
               n_drops);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // hang guard, far above the slowest legal run
   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
